FILE: sv/dwsp_pkg.sv
// ----------------------------------------------------------------------------
// dwsp_pkg: shared definitions for the deque with search and purge
// Opcodes, status codes, default depth and the result bundle.
// ----------------------------------------------------------------------------
package dwsp_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KEY_W     = 32;
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;
	// input tdata: opcode and key, padded to whole bytes
	localparam int IN_TDATA_W = ((OP_W + KEY_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [KEY_W-1:0] data;
	} result_t;

endpackage

FILE: sv/deque_with_search_and_purge_top.sv
// ----------------------------------------------------------------------------
// deque_with_search_and_purge_top: bounded deque of 32-bit keys
// Push/pop at both ends, find first match, remove all matches, clear.
// ----------------------------------------------------------------------------
// Usage:
//   One request item enters on s_axis (opcode, key); exactly one result item
//   leaves on m_axis (status, data_out, entry_count) for each request.
//   Items are handled one at a time, in order.
// Steps from accept to result valid:
//   push, clear, no-op and push/pop on full/empty: S_EXEC, then S_FIN;
//   pop: S_EXEC, S_RD (one read of the key store), then S_FIN;
//   find / remove all: S_EXEC, S_SCAN over at most DEPTH positions, then S_FIN.
//   The walk reads one stored entry per cycle through the single read port
//   of the key store, so find and remove set the worst case rate.
// Throughput: the next request can be taken in the cycle after the result leaves
//   the sequencer; no new request is taken while one is still in progress, so
//   a full walk gives the slowest rate.
// Reset: arst_n clears the entry count and the front slot; the key store
//   itself is not cleared, since only stored entries are ever used.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and its result holds back until m_axis drains.
// ----------------------------------------------------------------------------
module deque_with_search_and_purge_top #(
	parameter int DEPTH = dwsp_pkg::DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1),
	localparam int OUT_TDATA_W = ((dwsp_pkg::ST_W + dwsp_pkg::KEY_W + CW + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [2:0] opcode, [34:3] key_in, rest zero
	input  logic [dwsp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [1:0] status, [33:2] data_out, [33+CW:34] entry_count, rest zero
	output logic [OUT_TDATA_W-1:0]          m_axis_tdata
);

	// controller to output register
	logic              res_valid;
	logic              res_ready;
	dwsp_pkg::result_t res;
	logic [CW-1:0]     count;

	// key store port
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [dwsp_pkg::KEY_W-1:0] mem_wdata;
	logic [AW-1:0]              mem_raddr;
	logic [dwsp_pkg::KEY_W-1:0] mem_rdata;

	// output register
	logic              out_valid_q;
	dwsp_pkg::result_t out_res_q;
	logic [CW-1:0]     out_count_q;

	dwsp_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tdata[dwsp_pkg::OP_W-1:0]),
		.in_key    (s_axis_tdata[dwsp_pkg::OP_W +: dwsp_pkg::KEY_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.count     (count),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	dwsp_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// load a fresh result when the register is empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q   <= res;
			out_count_q <= count;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_count_q, out_res_q.data, out_res_q.status});

endmodule

FILE: sv/dwsp_ram.sv
// ----------------------------------------------------------------------------
// dwsp_ram: key store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dwsp_ram #(
	parameter int DEPTH = dwsp_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [dwsp_pkg::KEY_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [dwsp_pkg::KEY_W-1:0] rdata
);

	logic [dwsp_pkg::KEY_W-1:0] mem [DEPTH];
	logic [dwsp_pkg::KEY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/dwsp_ctrl.sv
// ----------------------------------------------------------------------------
// dwsp_ctrl: request sequencer
// Decodes one request, drives the key store and walks it for find/remove.
// ----------------------------------------------------------------------------
module dwsp_ctrl #(
	parameter int DEPTH = dwsp_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dwsp_pkg::OP_W-1:0]  in_op,
	input  logic [dwsp_pkg::KEY_W-1:0] in_key,
	output logic                       res_valid,
	input  logic                       res_ready,
	output dwsp_pkg::result_t          res,
	output logic [CW-1:0]              count,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [dwsp_pkg::KEY_W-1:0] mem_wdata,
	output logic [AW-1:0]              mem_raddr,
	input  logic [dwsp_pkg::KEY_W-1:0] mem_rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]                 state_q;
	logic [dwsp_pkg::OP_W-1:0]  op_q;
	logic [dwsp_pkg::KEY_W-1:0] key_q;
	logic [AW-1:0]              front_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              pos_q;
	logic [CW-1:0]              kept_q;
	dwsp_pkg::result_t          res_q;

	logic          full;
	logic          empty;
	logic          match;
	logic          last;
	logic [AW-1:0] front_dec;
	logic [CW-1:0] kept_next;

	// ring slot of the entry at a given position from the front
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] pos);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(pos);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign match     = (mem_rdata == key_q);
	assign last      = ((pos_q + CW'(1)) == count_q);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign kept_next = match ? kept_q : kept_q + CW'(1);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;
	assign count     = count_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = front_dec;
		mem_wdata = key_q;
		mem_raddr = front_q;
		if (state_q == S_EXEC) begin
			case (op_q) inside
				dwsp_pkg::OP_PUSH_FRONT: begin
					mem_we = !full;
				end
				dwsp_pkg::OP_PUSH_BACK: begin
					mem_we    = !full;
					mem_waddr = slot(front_q, count_q);
				end
				dwsp_pkg::OP_POP_BACK: begin
					mem_raddr = slot(front_q, count_q - CW'(1));
				end
				default: begin
					mem_raddr = front_q;
				end
			endcase
		end else if (state_q == S_SCAN) begin
			mem_raddr = slot(front_q, pos_q + CW'(1));
			if (op_q == dwsp_pkg::OP_REMOVE) begin
				// compact survivors toward the front; kept never passes pos
				mem_we    = !match;
				mem_waddr = slot(front_q, kept_q);
				mem_wdata = mem_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q) inside
						dwsp_pkg::OP_PUSH_FRONT: begin
							state_q <= S_FIN;
							if (!full) begin
								front_q <= front_dec;
								count_q <= count_q + CW'(1);
							end
						end
						dwsp_pkg::OP_PUSH_BACK: begin
							state_q <= S_FIN;
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end
						dwsp_pkg::OP_POP_FRONT, dwsp_pkg::OP_POP_BACK: begin
							if (!empty) begin
								state_q <= S_RD;
								count_q <= count_q - CW'(1);
								if (op_q == dwsp_pkg::OP_POP_FRONT) begin
									front_q <= slot(front_q, CW'(1));
								end
							end else begin
								state_q <= S_FIN;
							end
						end
						dwsp_pkg::OP_FIND, dwsp_pkg::OP_REMOVE: begin
							state_q <= empty ? S_FIN : S_SCAN;
						end
						dwsp_pkg::OP_CLEAR: begin
							state_q <= S_FIN;
							count_q <= '0;
							front_q <= '0;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_RD: begin
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (op_q == dwsp_pkg::OP_FIND) begin
						if (match || last) begin
							state_q <= S_FIN;
						end
					end else if (last) begin
						count_q <= kept_next;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side: request, walk counters and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q  <= in_op;
					key_q <= in_key;
				end
			end
			S_EXEC: begin
				pos_q  <= '0;
				kept_q <= '0;
				case (op_q) inside
					dwsp_pkg::OP_PUSH_FRONT, dwsp_pkg::OP_PUSH_BACK: begin
						res_q <= '{status: full ? dwsp_pkg::ST_FULL : dwsp_pkg::ST_OK,
							data: '0};
					end
					dwsp_pkg::OP_POP_FRONT, dwsp_pkg::OP_POP_BACK: begin
						res_q <= '{status: empty ? dwsp_pkg::ST_EMPTY : dwsp_pkg::ST_OK,
							data: '0};
					end
					dwsp_pkg::OP_FIND: begin
						res_q <= '{status: empty ? dwsp_pkg::ST_NOT_FOUND : dwsp_pkg::ST_OK,
							data: '0};
					end
					default: begin
						res_q <= '{status: dwsp_pkg::ST_OK, data: '0};
					end
				endcase
			end
			S_RD: begin
				res_q <= '{status: dwsp_pkg::ST_OK, data: mem_rdata};
			end
			S_SCAN: begin
				pos_q  <= pos_q + CW'(1);
				kept_q <= kept_next;
				if (op_q == dwsp_pkg::OP_FIND) begin
					if (match) begin
						res_q <= '{status: dwsp_pkg::ST_OK, data: dwsp_pkg::KEY_W'(pos_q)};
					end else if (last) begin
						res_q <= '{status: dwsp_pkg::ST_NOT_FOUND, data: '0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= AW'(DEPTH - 1))
		else $error("front slot out of range");

	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (pos_q < count_q))
		else $error("walk position past stored entries");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_EXEC || state_q == S_SCAN))
		else $error("key store written outside execute or walk");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted item did not start");

endmodule
